/* src/ppf_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ppf_pkg
// Shared constants, codes, types and index helper for the polyline path
// follower.
// ----------------------------------------------------------------------------
package ppf_pkg;

    // Sizes of the waypoint store and of the arithmetic.
    localparam int MAX_POINTS = 64;
    localparam int IDX_W      = $clog2(MAX_POINTS);
    localparam int CNT_W      = IDX_W + 1;
    localparam int COORD_W    = 16;
    localparam int SPD_W      = 8;
    localparam int NUM_W      = COORD_W + SPD_W + 1;
    localparam int ITER_W     = 3;
    localparam int CFG_IDX_W  = 2;

    // Request operation codes.
    localparam logic [1:0] FN_CLEAR  = 2'd0;
    localparam logic [1:0] FN_APPEND = 2'd1;
    localparam logic [1:0] FN_START  = 2'd2;
    localparam logic [1:0] FN_TICK   = 2'd3;

    // Result status codes.
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    // Facing codes.
    localparam logic [1:0] FACE_NONE  = 2'd0;
    localparam logic [1:0] FACE_RIGHT = 2'd1;
    localparam logic [1:0] FACE_LEFT  = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LOOP  = 2'd2;

    // First iteration indexes of the remainder and quotient loops.
    localparam logic [ITER_W-1:0] MOD_FIRST = ITER_W'(IDX_W - 1);
    localparam logic [ITER_W-1:0] DIV_FIRST = ITER_W'(SPD_W - 1);

    // Controller states.
    typedef enum logic [3:0] {
        S_IDLE,
        S_EXEC,
        S_MOD,
        S_SRD,
        S_SLD,
        S_TRD,
        S_PREP,
        S_MUL,
        S_DIV,
        S_UPD,
        S_DONE
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic exec;
        logic mod_step;
        logic rd_tick;
        logic start_load;
        logic prep;
        logic mul;
        logic div_step;
        logic update;
        logic out_load;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [1:0] func;
        logic       cnt_zero;
        logic       live_zero;
        logic       iter_zero;
    } t_dp_stat;

    // Index of the waypoint after p in the given direction.
    function automatic logic [IDX_W-1:0] f_next_idx(
        input logic [IDX_W-1:0] p,
        input logic             fwd,
        input logic [CNT_W-1:0] cnt,
        input logic             closed
    );
        logic [CNT_W-1:0] last_w;
        logic [IDX_W-1:0] last;
        logic [IDX_W-1:0] fin;
        logic [IDX_W-1:0] res;
        last_w = cnt - CNT_W'(1);
        last   = last_w[IDX_W-1:0];
        fin    = fwd ? last : '0;
        if (p != fin) begin
            res = fwd ? p + IDX_W'(1) : p - IDX_W'(1);
        end else if (closed) begin
            res = '0;
        end else if (cnt > CNT_W'(1)) begin
            res = fwd ? p - IDX_W'(1) : p + IDX_W'(1);
        end else begin
            res = p;
        end
        return res;
    endfunction

endpackage
`default_nettype wire

/* src/ppf_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ppf_ctrl
// Sequencer for the path follower: walks each request through the datapath
// and owns the request and result handshakes.
// ----------------------------------------------------------------------------
module ppf_ctrl
    import ppf_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_stall,
    output logic          o_out_valid,
    input  wire logic     i_out_stall,
    input  wire t_dp_stat i_stat,
    output t_dp_cmd       o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   w_out_free;

    // The result register is free when empty or being taken now.
    assign w_out_free = !r_out_valid || !i_out_stall;

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_EXEC;
            end
            S_EXEC: begin
                if (i_stat.func == FN_START && !i_stat.cnt_zero) begin
                    n_state = S_MOD;
                end else if (i_stat.func == FN_TICK && !i_stat.cnt_zero &&
                             !i_stat.live_zero) begin
                    n_state = S_TRD;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_MOD: begin
                if (i_stat.iter_zero) n_state = S_SRD;
            end
            S_SRD:  n_state = S_SLD;
            S_SLD:  n_state = S_DONE;
            S_TRD:  n_state = S_PREP;
            S_PREP: n_state = S_MUL;
            S_MUL:  n_state = S_DIV;
            S_DIV: begin
                if (i_stat.iter_zero) n_state = S_UPD;
            end
            S_UPD:  n_state = S_DONE;
            S_DONE: begin
                if (w_out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Commands decoded from the state.
    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            S_IDLE: o_cmd.accept     = i_in_valid;
            S_EXEC: o_cmd.exec       = 1'b1;
            S_MOD:  o_cmd.mod_step   = 1'b1;
            S_SRD:  o_cmd.rd_tick    = 1'b0;
            S_SLD:  o_cmd.start_load = 1'b1;
            S_TRD:  o_cmd.rd_tick    = 1'b1;
            S_PREP: o_cmd.prep       = 1'b1;
            S_MUL:  o_cmd.mul        = 1'b1;
            S_DIV:  o_cmd.div_step   = 1'b1;
            S_UPD:  o_cmd.update     = 1'b1;
            S_DONE: o_cmd.out_load   = w_out_free;
            default: o_cmd = '0;
        endcase
    end

    // State and result valid registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule
`default_nettype wire

/* src/ppf_datapath.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ppf_datapath
// Waypoint store, follower state, Bresenham step arithmetic with two
// shift-subtract loops, configuration registers and the result register.
// ----------------------------------------------------------------------------
module ppf_datapath
    import ppf_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire t_dp_cmd              i_cmd,
    output t_dp_stat                  o_stat,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [SPD_W-1:0]     i_cfg_data,
    input  wire logic [1:0]           i_func,
    input  wire logic [COORD_W-1:0]   i_point_x,
    input  wire logic [COORD_W-1:0]   i_point_y,
    output logic [COORD_W-1:0]        o_pos_x,
    output logic [COORD_W-1:0]        o_pos_y,
    output logic [1:0]                o_facing,
    output logic [IDX_W-1:0]          o_point_index,
    output logic                      o_going_forward,
    output logic                      o_active,
    output logic [1:0]                o_status
);

    // Waypoint memory.
    logic [COORD_W-1:0] r_mem_x [MAX_POINTS];
    logic [COORD_W-1:0] r_mem_y [MAX_POINTS];
    logic [COORD_W-1:0] r_rd_x;
    logic [COORD_W-1:0] r_rd_y;
    logic [IDX_W-1:0]   w_rd_addr;

    // Configuration.
    logic [SPD_W-1:0] r_speed;
    logic [IDX_W-1:0] r_start_pt;
    logic             r_loop_en;

    // Follower state.
    logic [CNT_W-1:0]   r_cnt;
    logic [COORD_W-1:0] r_first_x, r_first_y, r_last_x, r_last_y;
    logic [COORD_W-1:0] r_cur_x, r_cur_y;
    logic [IDX_W-1:0]   r_cur_pt;
    logic               r_fwd;
    logic [SPD_W-1:0]   r_live;
    logic               r_loop;
    logic [1:0]         r_face;
    logic [1:0]         r_status;

    // Latched request.
    logic [1:0]         r_func;
    logic [COORD_W-1:0] r_in_x, r_in_y;

    // Step working registers.
    logic [IDX_W-1:0]   r_nxt;
    logic [COORD_W-1:0] r_m, r_n;
    logic [SPD_W-1:0]   r_adv;
    logic               r_xmaj, r_reach;
    logic               r_sx_nz, r_sx_neg, r_sy_nz, r_sy_neg;
    logic [NUM_W-1:0]   r_num;
    logic [SPD_W-1:0]   r_q;
    logic [IDX_W-1:0]   r_rem;
    logic [ITER_W-1:0]  r_iter;

    logic               w_closed;
    logic               w_full;
    logic [IDX_W-1:0]   w_nxt;

    assign w_closed = (r_first_x == r_last_x) && (r_first_y == r_last_y);
    assign w_full   = (r_cnt == CNT_W'(MAX_POINTS));
    assign w_nxt    = f_next_idx(r_cur_pt, r_fwd, r_cnt, w_closed);

    assign o_stat.func      = r_func;
    assign o_stat.cnt_zero  = (r_cnt == '0);
    assign o_stat.live_zero = (r_live == '0);
    assign o_stat.iter_zero = (r_iter == '0);

    // Memory write on append, registered read every cycle.
    assign w_rd_addr = i_cmd.rd_tick ? w_nxt : r_rem;

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && r_func == FN_APPEND && !w_full) begin
            r_mem_x[r_cnt[IDX_W-1:0]] <= r_in_x;
            r_mem_y[r_cnt[IDX_W-1:0]] <= r_in_y;
        end
        r_rd_x <= r_mem_x[w_rd_addr];
        r_rd_y <= r_mem_y[w_rd_addr];
    end

    // Axis distances for the step toward the read waypoint.
    logic signed [COORD_W:0] w_dx, w_dy;
    logic [COORD_W:0]        w_ax_w, w_ay_w;
    logic [COORD_W-1:0]      w_ax, w_ay, w_m, w_n;
    logic                    w_xmaj;

    always_comb begin
        w_dx   = $signed({r_rd_x[COORD_W-1], r_rd_x}) - $signed({r_cur_x[COORD_W-1], r_cur_x});
        w_dy   = $signed({r_rd_y[COORD_W-1], r_rd_y}) - $signed({r_cur_y[COORD_W-1], r_cur_y});
        w_ax_w = w_dx[COORD_W] ? $unsigned(-w_dx) : $unsigned(w_dx);
        w_ay_w = w_dy[COORD_W] ? $unsigned(-w_dy) : $unsigned(w_dy);
        w_ax   = w_ax_w[COORD_W-1:0];
        w_ay   = w_ay_w[COORD_W-1:0];
        w_xmaj = (w_ax > w_ay);
        w_m    = w_xmaj ? w_ax : w_ay;
        w_n    = w_xmaj ? w_ay : w_ax;
    end

    // Remainder step for the start index and quotient step for the minor axis.
    logic [IDX_W+CNT_W-1:0] w_mod_rem, w_mod_dvs;
    logic [NUM_W-1:0]       w_div_dvs;

    always_comb begin
        w_mod_rem = {{CNT_W{1'b0}}, r_rem};
        w_mod_dvs = {{IDX_W{1'b0}}, r_cnt} << r_iter;
        w_div_dvs = {{(NUM_W-COORD_W){1'b0}}, r_m} << r_iter;
    end

    // Position update at the end of a tick.
    logic [SPD_W-1:0]        w_q, w_amt_x, w_amt_y;
    logic signed [COORD_W:0] w_step_x, w_step_y;
    logic [COORD_W:0]        w_sum_x, w_sum_y;
    logic [IDX_W-1:0]        w_nxt2;

    always_comb begin
        w_q      = (r_m == '0) ? '0 : r_q;
        w_amt_x  = r_xmaj ? r_adv : w_q;
        w_amt_y  = r_xmaj ? w_q : r_adv;
        w_step_x = !r_sx_nz ? '0 :
                   r_sx_neg ? -$signed({{(COORD_W+1-SPD_W){1'b0}}, w_amt_x})
                            :  $signed({{(COORD_W+1-SPD_W){1'b0}}, w_amt_x});
        w_step_y = !r_sy_nz ? '0 :
                   r_sy_neg ? -$signed({{(COORD_W+1-SPD_W){1'b0}}, w_amt_y})
                            :  $signed({{(COORD_W+1-SPD_W){1'b0}}, w_amt_y});
        w_sum_x  = {1'b0, r_cur_x} + $unsigned(w_step_x);
        w_sum_y  = {1'b0, r_cur_y} + $unsigned(w_step_y);
        w_nxt2   = f_next_idx(r_nxt, r_fwd, r_cnt, w_closed);
    end

    // Request latch and step working registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_func <= i_func;
            r_in_x <= i_point_x;
            r_in_y <= i_point_y;
        end
        if (i_cmd.exec) begin
            r_rem  <= r_start_pt;
            r_iter <= MOD_FIRST;
        end
        if (i_cmd.mod_step) begin
            if (w_mod_rem >= w_mod_dvs) begin
                r_rem <= IDX_W'(w_mod_rem - w_mod_dvs);
            end
            r_iter <= r_iter - ITER_W'(1);
        end
        if (i_cmd.rd_tick) begin
            r_nxt <= w_nxt;
        end
        if (i_cmd.prep) begin
            r_m      <= w_m;
            r_n      <= w_n;
            r_xmaj   <= w_xmaj;
            r_reach  <= (w_m < {{(COORD_W-SPD_W){1'b0}}, r_live});
            r_adv    <= (w_m < {{(COORD_W-SPD_W){1'b0}}, r_live}) ? w_m[SPD_W-1:0] : r_live;
            r_sx_nz  <= (w_dx != '0);
            r_sx_neg <= w_dx[COORD_W];
            r_sy_nz  <= (w_dy != '0);
            r_sy_neg <= w_dy[COORD_W];
        end
        if (i_cmd.mul) begin
            r_num  <= NUM_W'(r_m >> 1) + NUM_W'(r_n) * NUM_W'(r_adv);
            r_q    <= '0;
            r_iter <= DIV_FIRST;
        end
        if (i_cmd.div_step) begin
            if (r_num >= w_div_dvs) begin
                r_num       <= r_num - w_div_dvs;
                r_q[r_iter] <= 1'b1;
            end
            r_iter <= r_iter - ITER_W'(1);
        end
    end

    // Path, follower and configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt     <= '0;
            r_cur_x   <= '0;
            r_cur_y   <= '0;
            r_cur_pt  <= '0;
            r_fwd     <= 1'b1;
            r_live    <= '0;
            r_loop    <= 1'b0;
            r_face    <= FACE_NONE;
            r_status  <= ST_OK;
            r_speed   <= SPD_W'(1);
            r_start_pt <= '0;
            r_loop_en <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_SPEED: r_speed    <= i_cfg_data;
                    CFG_START: r_start_pt <= i_cfg_data[IDX_W-1:0];
                    CFG_LOOP:  r_loop_en  <= i_cfg_data[0];
                    default:   ;
                endcase
            end
            // Immediate part of every request.
            if (i_cmd.exec) begin
                r_status <= ST_OK;
                unique case (r_func)
                    FN_CLEAR: begin
                        r_cnt  <= '0;
                        r_live <= '0;
                    end
                    FN_APPEND: begin
                        if (w_full) begin
                            r_status <= ST_FULL;
                        end else begin
                            if (r_cnt == '0) begin
                                r_first_x <= r_in_x;
                                r_first_y <= r_in_y;
                            end
                            r_last_x <= r_in_x;
                            r_last_y <= r_in_y;
                            r_cnt    <= r_cnt + CNT_W'(1);
                        end
                    end
                    default: begin
                        if (r_cnt == '0) r_status <= ST_EMPTY;
                    end
                endcase
            end
            // Start: place the follower on the chosen waypoint.
            if (i_cmd.start_load) begin
                r_cur_pt <= r_rem;
                r_fwd    <= 1'b1;
                r_live   <= r_speed;
                r_loop   <= r_loop_en;
                r_face   <= FACE_NONE;
                r_cur_x  <= r_rd_x;
                r_cur_y  <= r_rd_y;
            end
            // Tick: move and handle arrival at a waypoint.
            if (i_cmd.update) begin
                r_cur_x <= w_sum_x[COORD_W-1:0];
                r_cur_y <= w_sum_y[COORD_W-1:0];
                if (r_sx_nz && w_amt_x != '0) begin
                    r_face <= r_sx_neg ? FACE_LEFT : FACE_RIGHT;
                end
                if (r_reach) begin
                    r_cur_pt <= r_nxt;
                    if (w_nxt2 == '0 && r_nxt > IDX_W'(1)) begin
                        if (!r_loop) r_live <= '0;
                    end else if (w_nxt2 < r_nxt) begin
                        if (!r_loop && r_fwd) r_live <= '0;
                        r_fwd <= 1'b0;
                    end else if (w_nxt2 != '0 && r_nxt == '0) begin
                        if (!r_loop && !r_fwd) r_live <= '0;
                        r_fwd <= 1'b1;
                    end else begin
                        r_fwd <= 1'b1;
                    end
                end
            end
        end
    end

    // First and last points need no reset; they are read only once written.
    // Result register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_pos_x         <= r_cur_x;
            o_pos_y         <= r_cur_y;
            o_facing        <= r_face;
            o_point_index   <= r_cur_pt;
            o_going_forward <= r_fwd;
            o_active        <= (r_live != '0);
            o_status        <= r_status;
        end
    end

endmodule
`default_nettype wire

/* src/polyline_path_follower.sv */
`timescale 1ns / 1ps
`default_nettype none
// A tick request runs the eight-step quotient loop and a start runs the
// six-step index remainder loop; clear and append need neither loop.
// One request is in work at a time; the next is taken once the result is
// registered, while that result may still wait at the output.
// Reset is synchronous and active low; the waypoint store is not cleared.
// ----------------------------------------------------------------------------
// polyline_path_follower
// Top level: stores a polyline of waypoints and moves a follower along it.
// ----------------------------------------------------------------------------
module polyline_path_follower
    import ppf_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire logic [1:0]           i_func,
    input  wire logic [COORD_W-1:0]   i_point_x,
    input  wire logic [COORD_W-1:0]   i_point_y,
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output logic [COORD_W-1:0]        o_pos_x,
    output logic [COORD_W-1:0]        o_pos_y,
    output logic [1:0]                o_facing,
    output logic [IDX_W-1:0]          o_point_index,
    output logic                      o_going_forward,
    output logic                      o_active,
    output logic [1:0]                o_status,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [SPD_W-1:0]     i_cfg_data
);

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    // Configuration writes are always taken.
    assign o_cfg_ready = 1'b1;

    ppf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    ppf_datapath u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_stat          (w_stat),
        .i_cfg_we        (i_cfg_valid),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_func          (i_func),
        .i_point_x       (i_point_x),
        .i_point_y       (i_point_y),
        .o_pos_x         (o_pos_x),
        .o_pos_y         (o_pos_y),
        .o_facing        (o_facing),
        .o_point_index   (o_point_index),
        .o_going_forward (o_going_forward),
        .o_active        (o_active),
        .o_status        (o_status)
    );

endmodule
`default_nettype wire

/* tb/ppf_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppf_checker
// Watches the request, result and register channels of the polyline path
// follower. It keeps its own copy of the path and follower state, works out
// the result of every accepted request, and compares each result field by
// field with the oldest one that is still waiting.
// ----------------------------------------------------------------------------
module ppf_checker
    import ppf_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_stall,
    input  logic [1:0]           i_func,
    input  logic [COORD_W-1:0]   i_point_x,
    input  logic [COORD_W-1:0]   i_point_y,
    input  logic                 i_out_valid,
    input  logic                 i_out_stall,
    input  logic [COORD_W-1:0]   i_pos_x,
    input  logic [COORD_W-1:0]   i_pos_y,
    input  logic [1:0]           i_facing,
    input  logic [IDX_W-1:0]     i_point_index,
    input  logic                 i_going_forward,
    input  logic                 i_active,
    input  logic [1:0]           i_status,
    input  logic                 i_cfg_valid,
    input  logic                 i_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [SPD_W-1:0]     i_cfg_data,
    output int                   o_fail_count,
    output int                   o_pending
);

    typedef struct packed {
        logic [COORD_W-1:0] pos_x;
        logic [COORD_W-1:0] pos_y;
        logic [1:0]         facing;
        logic [IDX_W-1:0]   point_index;
        logic               going_forward;
        logic               active;
        logic [1:0]         status;
    } t_follow_res;

    // Shadow copy of the path, the follower and the registers.
    longint      path_x [MAX_POINTS];
    longint      path_y [MAX_POINTS];
    int          path_len;
    longint      at_x;
    longint      at_y;
    int          at_idx;
    bit          fwd;
    int          run_speed;
    bit          run_loop;
    logic [1:0]  face;
    int          reg_speed;
    int          reg_start;
    bit          reg_loop;

    t_follow_res awaited_q[$];
    int          fails;

    assign o_fail_count = fails;
    assign o_pending    = awaited_q.size();

    // Waypoint after p in direction d, wrapping on a closed path.
    function automatic int step_index(int p, bit d);
        int last;
        int fin;
        last = path_len - 1;
        fin  = d ? last : 0;
        if (p != fin) return d ? p + 1 : p - 1;
        if (path_x[0] == path_x[last] && path_y[0] == path_y[last]) return 0;
        if (path_len > 1) return d ? p - 1 : p + 1;
        return p;
    endfunction

    // One tick of motion toward the next waypoint.
    task automatic advance_follower();
        int     nxt;
        int     reached;
        longint dx, dy, sx, sy, m, n, mx, my, t, adv, q, r, rx, ry;
        nxt = step_index(at_idx, fwd);
        dx  = path_x[nxt] - at_x;
        dy  = path_y[nxt] - at_y;
        sx  = (dx > 0) ? 1 : ((dx < 0) ? -1 : 0);
        sy  = (dy > 0) ? 1 : ((dy < 0) ? -1 : 0);
        m   = (dx < 0) ? -dx : dx;
        n   = (dy < 0) ? -dy : dy;
        mx  = sx;
        my  = 0;
        if (m <= n) begin
            t  = m;
            mx = 0;
            my = sy;
            m  = n;
            n  = t;
        end
        adv = run_speed;
        if (m < adv) adv = m;
        q  = (m == 0) ? 0 : ((m >>> 1) + n * adv) / m;
        r  = adv - q;
        rx = at_x + mx * r + sx * q;
        ry = at_y + my * r + sy * q;
        // Short of the full speed means the waypoint was reached.
        if (adv < run_speed) begin
            reached = nxt;
            at_idx  = reached;
            nxt     = step_index(reached, fwd);
            if (nxt == 0 && reached > 1) begin
                if (!run_loop) run_speed = 0;
            end else if (nxt < reached) begin
                if (!run_loop && fwd) run_speed = 0;
                fwd = 0;
            end else if (nxt > 0 && reached == 0) begin
                if (!run_loop && !fwd) run_speed = 0;
                fwd = 1;
            end else begin
                fwd = 1;
            end
        end
        if (rx != at_x) face = (rx > at_x) ? FACE_RIGHT : FACE_LEFT;
        at_x = rx;
        at_y = ry;
    endtask

    // Apply one request to the shadow state and queue its result.
    task automatic predict_request(logic [1:0] fn, logic [COORD_W-1:0] px,
                                   logic [COORD_W-1:0] py);
        t_follow_res res;
        logic [1:0]  st;
        st = ST_OK;
        if (fn == FN_CLEAR) begin
            path_len  = 0;
            run_speed = 0;
        end else if (fn == FN_APPEND) begin
            if (path_len < MAX_POINTS) begin
                path_x[path_len] = longint'($signed(px));
                path_y[path_len] = longint'($signed(py));
                path_len++;
            end else begin
                st = ST_FULL;
            end
        end else if (path_len == 0) begin
            st = ST_EMPTY;
        end else if (fn == FN_START) begin
            at_idx    = reg_start % path_len;
            fwd       = 1;
            run_speed = reg_speed;
            run_loop  = reg_loop;
            face      = FACE_NONE;
            at_x      = path_x[at_idx];
            at_y      = path_y[at_idx];
        end else if (run_speed != 0) begin
            advance_follower();
        end
        res.pos_x         = at_x[COORD_W-1:0];
        res.pos_y         = at_y[COORD_W-1:0];
        res.facing        = face;
        res.point_index   = at_idx[IDX_W-1:0];
        res.going_forward = fwd;
        res.active        = (run_speed != 0);
        res.status        = st;
        awaited_q.push_back(res);
    endtask

    // Observe the three channels on every rising edge.
    always @(posedge i_clk) begin
        t_follow_res want;
        t_follow_res got;
        if (!i_rst_n) begin
            path_len  = 0;
            at_x      = 0;
            at_y      = 0;
            at_idx    = 0;
            fwd       = 1;
            run_speed = 0;
            run_loop  = 0;
            face      = FACE_NONE;
            reg_speed = 1;
            reg_start = 0;
            reg_loop  = 0;
            fails     = 0;
            awaited_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_SPEED: reg_speed = i_cfg_data;
                    CFG_START: reg_start = i_cfg_data[IDX_W-1:0];
                    CFG_LOOP:  reg_loop  = i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                got = '{i_pos_x, i_pos_y, i_facing, i_point_index, i_going_forward,
                        i_active, i_status};
                if (awaited_q.size() == 0) begin
                    fails++;
                    if (fails <= 10) $display("Unexpected result %p", got);
                end else begin
                    want = awaited_q.pop_front();
                    if (got !== want) begin
                        fails++;
                        if (fails <= 10)
                            $display("Mismatch: expected %p, actual %p", want, got);
                    end
                end
            end
            if (i_in_valid && !i_in_stall) predict_request(i_func, i_point_x, i_point_y);
        end
    end

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives paths of waypoints, register settings and streams of ticks into the
// polyline path follower, with random gaps and output stalls, and gives the
// verdict from the failure count of the checker.
// ----------------------------------------------------------------------------
module testbench;
    import ppf_pkg::*;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    logic [1:0]           func;
    logic [COORD_W-1:0]   point_x;
    logic [COORD_W-1:0]   point_y;
    logic                 out_valid;
    logic                 out_stall;
    logic [COORD_W-1:0]   pos_x;
    logic [COORD_W-1:0]   pos_y;
    logic [1:0]           facing;
    logic [IDX_W-1:0]     point_index;
    logic                 going_forward;
    logic                 active;
    logic [1:0]           status;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [SPD_W-1:0]     cfg_data;
    int                   fail_count;
    int                   pending;
    int                   sent;
    bit                   calm;

    polyline_path_follower u_top (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .o_in_stall(in_stall),
        .i_func(func), .i_point_x(point_x), .i_point_y(point_y),
        .o_out_valid(out_valid), .i_out_stall(out_stall),
        .o_pos_x(pos_x), .o_pos_y(pos_y), .o_facing(facing),
        .o_point_index(point_index), .o_going_forward(going_forward),
        .o_active(active), .o_status(status),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data)
    );

    ppf_checker u_checker (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .i_in_stall(in_stall),
        .i_func(func), .i_point_x(point_x), .i_point_y(point_y),
        .i_out_valid(out_valid), .i_out_stall(out_stall),
        .i_pos_x(pos_x), .i_pos_y(pos_y), .i_facing(facing),
        .i_point_index(point_index), .i_going_forward(going_forward),
        .i_active(active), .i_status(status),
        .i_cfg_valid(cfg_valid), .i_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // Clock.
    initial begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    // Result side stalls at random, except in the calm stretch.
    always @(negedge clk) begin
        out_stall <= !calm && ($urandom_range(99) < 11);
    end

    // Overall time limit.
    initial begin
        #5ms;
        $display("Test completed with failures");
        $finish;
    end

    // Send one request and wait until it is taken.
    task automatic send_request(logic [1:0] fn, logic [COORD_W-1:0] px,
                                logic [COORD_W-1:0] py);
        while (!calm && $urandom_range(99) < 11) begin
            in_valid = 0;
            @(negedge clk);
        end
        in_valid = 1;
        func     = fn;
        point_x  = px;
        point_y  = py;
        do @(posedge clk); while (in_stall);
        @(negedge clk);
        in_valid = 0;
        sent++;
    endtask

    // Register write, only issued while the block is idle.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [SPD_W-1:0] val);
        cfg_valid = 1;
        cfg_index = idx;
        cfg_data  = val;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid = 0;
    endtask

    // Let every expected result arrive, then allow for the tick latency.
    task automatic wait_idle();
        while (pending != 0) @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    // Random coordinate, near the origin or anywhere in range.
    function automatic logic [COORD_W-1:0] pick_coord(bit wide);
        return wide ? COORD_W'($urandom) : COORD_W'($urandom_range(80) - 40);
    endfunction

    // One whole scenario: settings, a fresh path, a start and a run of ticks.
    task automatic run_path(int npts, bit closed, int spd, int sp, bit lp,
                            int nticks, bit wide, bit noisy);
        logic [COORD_W-1:0] fx, fy, px, py;
        wait_idle();
        write_reg(CFG_SPEED, SPD_W'(spd));
        write_reg(CFG_START, SPD_W'(sp));
        write_reg(CFG_LOOP, SPD_W'(lp));
        send_request(FN_CLEAR, pick_coord(1), pick_coord(1));
        fx = pick_coord(wide);
        fy = pick_coord(wide);
        for (int k = 0; k < npts; k++) begin
            px = (k == 0 || (closed && k == npts - 1)) ? fx : pick_coord(wide);
            py = (k == 0 || (closed && k == npts - 1)) ? fy : pick_coord(wide);
            send_request(FN_APPEND, px, py);
        end
        send_request(FN_START, pick_coord(1), pick_coord(1));
        for (int k = 0; k < nticks; k++) begin
            if (noisy && $urandom_range(99) < 8)
                send_request(2'($urandom), pick_coord(wide), pick_coord(wide));
            else
                send_request(FN_TICK, pick_coord(1), pick_coord(1));
        end
    endtask

    initial begin
        int npts;
        int spd;
        rst_n     = 0;
        in_valid  = 0;
        func      = FN_CLEAR;
        point_x   = '0;
        point_y   = '0;
        out_stall = 0;
        cfg_valid = 0;
        cfg_index = CFG_SPEED;
        cfg_data  = '0;
        sent      = 0;
        calm      = 0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // Empty path: start and tick report it, clear is harmless.
        send_request(FN_TICK, '0, '0);
        send_request(FN_START, '0, '0);
        send_request(FN_CLEAR, '0, '0);
        send_request(FN_TICK, '0, '0);
        // Extreme corners at top speed on a looping path.
        send_request(FN_APPEND, 16'h8000, 16'h8000);
        send_request(FN_APPEND, 16'h7fff, 16'h7fff);
        send_request(FN_APPEND, 16'h7fff, 16'h8000);
        wait_idle();
        write_reg(CFG_SPEED, 8'hff);
        write_reg(CFG_START, 8'hff);
        write_reg(CFG_LOOP, 8'h01);
        send_request(FN_START, '0, '0);
        repeat (6) send_request(FN_TICK, '0, '0);
        // Single point, inactive speed, closed path, overfull path.
        run_path(1, 0, 3, 0, 1, 3, 0, 0);
        run_path(3, 0, 0, 1, 0, 2, 0, 0);
        run_path(4, 1, 7, 63, 1, 10, 0, 0);
        run_path(MAX_POINTS + 2, 0, 40, 17, 0, 4, 1, 0);

        // Random scenarios, with a calm stretch in the middle.
        while (sent < 1100) begin
            calm = (sent > 450 && sent < 650);
            npts = ($urandom_range(99) < 3) ? MAX_POINTS + $urandom_range(3)
                                            : $urandom_range(8, 1);
            case ($urandom_range(9))
                0:       spd = 0;
                1:       spd = 255;
                2:       spd = $urandom_range(255);
                default: spd = $urandom_range(12, 1);
            endcase
            run_path(npts, $urandom_range(2) == 0, spd, $urandom_range(255),
                     $urandom_range(1), $urandom_range(30, 4),
                     $urandom_range(9) == 0, $urandom_range(3) == 0);
        end
        calm = 0;

        wait_idle();
        if (fail_count == 0 && pending == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

/* files.f */
src/ppf_pkg.sv
src/ppf_ctrl.sv
src/ppf_datapath.sv
src/polyline_path_follower.sv
tb/ppf_checker.sv
tb/testbench.sv
